// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DSTK_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define DSTK_ASSERT_NEVER(name, expr, clk, rst_n) \
  `DSTK_ASSERT(name, !(expr), clk, rst_n)
`else
`define DSTK_ASSERT(name, prop, clk, rst_n)
`define DSTK_ASSERT_NEVER(name, expr, clk, rst_n)
`endif
`endif

// File: rtl/dstk_pkg.sv
// ----------------------------------------------------------------------------
// dstk_pkg
// Types and constants shared by the descending stable top-k sorter.
// ----------------------------------------------------------------------------
package dstk_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned TagW   = 6;
  localparam int unsigned RankW  = 7;
  localparam int unsigned LimitW = 7;

  localparam logic [LimitW-1:0] LimitDefault = 7'd15;
  localparam logic [LimitW-1:0] MaxResults   = 7'd64;

  // register index
  localparam logic RegOutputLimit = 1'b0;

  typedef struct packed {
    logic [KeyW-1:0] sort_key;
    logic [TagW-1:0] record_tag;
    logic            last_record;
  } in_t;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [KeyW-1:0]  ranked_key;
    logic [TagW-1:0]  ranked_tag;
    logic             final_result;
  } out_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } rec_t;

  typedef struct packed {
    logic ins_en;    // insert the broadcast record
    logic shift_en;  // move every record one cell toward the head
  } cell_ctrl_t;

endpackage

// File: rtl/dstk_cell.sv
// ----------------------------------------------------------------------------
// dstk_cell
// One slot of the sorted record chain: compares, inserts, shifts.
// ----------------------------------------------------------------------------
module dstk_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic                 clk_i,
  input  dstk_pkg::cell_ctrl_t ctrl_i,
  input  logic [CntW-1:0]      count_i,
  input  dstk_pkg::rec_t       new_rec_i,
  input  dstk_pkg::rec_t       left_rec_i,
  input  logic                 left_ins_i,
  input  dstk_pkg::rec_t       right_rec_i,
  output dstk_pkg::rec_t       rec_o,
  output logic                 ins_o
);
  import dstk_pkg::*;

  rec_t rec_q;
  logic occupied;

  assign occupied = CntW'(Idx) < count_i;
  // strict less keeps equal keys in arrival order
  assign ins_o    = !occupied || (rec_q.key < new_rec_i.key);
  assign rec_o    = rec_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      rec_q <= right_rec_i;
    end else if (ctrl_i.ins_en && ins_o) begin
      rec_q <= left_ins_i ? left_rec_i : new_rec_i;
    end
  end

endmodule

// File: rtl/descending_stable_top_k_sorter.sv
// ----------------------------------------------------------------------------
// descending_stable_top_k_sorter
// Insertion-chain ranker emitting the top records by descending key.
// ----------------------------------------------------------------------------
// Records load one per cycle: every cell compares the arriving key at once and
// the chain opens a slot, so the row always holds the set in descending order
// with equal keys in arrival order. Records beyond MAX_RECORDS are dropped.
// After the beat marked last, input is held off while the row shifts toward
// the head cell, one result per cycle into the output register (slower if the
// sink stalls). For a set of R records, min(output_limit, R, 64) results are
// emitted, output_limit 0 acting as 1.
module descending_stable_top_k_sorter #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dstk_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dstk_pkg::out_t out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import dstk_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned ExtW = (CntW > LimitW) ? CntW : LimitW;
  localparam logic        StIdle = 1'b0;
  localparam logic        StEmit = 1'b1;

  logic              state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [LimitW-1:0] limit_q;
  logic [RankW-1:0]  rank_q, rank_d;
  logic [RankW-1:0]  rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_data_q;

  rec_t              recs [MAX_RECORDS];
  logic              ins  [MAX_RECORDS];
  rec_t              new_rec;
  cell_ctrl_t        ctrl;

  logic              in_acc, out_load, not_full;
  logic [CntW-1:0]   count_n;
  logic [LimitW-1:0] lim_eff;
  logic [ExtW-1:0]   cnt_ext, lim_ext;
  logic [RankW-1:0]  n_emit;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegOutputLimit) ? {{(32 - LimitW){1'b0}}, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitDefault;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegOutputLimit) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  // cell row
  assign new_rec.key   = in_data_i.sort_key;
  assign new_rec.tag   = in_data_i.record_tag;
  assign in_ready_o    = (state_q == StIdle);
  assign in_acc        = in_valid_i && in_ready_o;
  assign not_full      = count_q < CntW'(MAX_RECORDS);
  assign out_load      = (state_q == StEmit) && (!out_valid_q || out_ready_i);
  assign ctrl.ins_en   = in_acc && not_full;
  assign ctrl.shift_en = out_load;

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rec_t left_rec, right_rec;
    logic left_ins;
    if (i == 0) begin : g_head
      assign left_rec = new_rec;
      assign left_ins = 1'b0;
    end else begin : g_body
      assign left_rec = recs[i-1];
      assign left_ins = ins[i-1];
    end
    if (i == MAX_RECORDS - 1) begin : g_tail
      assign right_rec = recs[i];
    end else begin : g_mid
      assign right_rec = recs[i+1];
    end
    dstk_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .new_rec_i   (new_rec),
      .left_rec_i  (left_rec),
      .left_ins_i  (left_ins),
      .right_rec_i (right_rec),
      .rec_o       (recs[i]),
      .ins_o       (ins[i])
    );
  end

  // result count for the closing beat
  assign count_n = count_q + CntW'(ctrl.ins_en);
  assign lim_eff = (limit_q == '0)        ? LimitW'(1)  :
                   (limit_q > MaxResults) ? MaxResults : limit_q;
  assign cnt_ext = ExtW'(count_n);
  assign lim_ext = ExtW'(lim_eff);
  assign n_emit  = (cnt_ext < lim_ext) ? cnt_ext[RankW-1:0] : lim_eff;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rank_d      = rank_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          count_d = count_n;
          if (in_data_i.last_record) begin
            state_d = StEmit;
            rank_d  = RankW'(1);
            rem_d   = n_emit;
          end
        end
      end
      StEmit: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          rank_d      = rank_q + RankW'(1);
          rem_d       = rem_q - RankW'(1);
          if (rem_q == RankW'(1)) begin
            state_d = StIdle;
            count_d = '0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rank_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rank_q      <= rank_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.rank         <= rank_q;
      out_data_q.ranked_key   <= recs[0].key;
      out_data_q.ranked_tag   <= recs[0].tag;
      out_data_q.final_result <= (rem_q == RankW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `DSTK_ASSERT_NEVER(a_count_bound, count_q > CntW'(MAX_RECORDS), clk_i, rst_ni)
  `DSTK_ASSERT(a_emit_has_work, (state_q == StEmit) |-> (rem_q != '0 && count_q != '0), clk_i, rst_ni)
  `DSTK_ASSERT(a_final_ends_set, (out_load && rem_q == RankW'(1)) |=> (state_q == StIdle && count_q == '0), clk_i, rst_ni)

endmodule

// File: sim/tb_descending_stable_top_k_sorter.sv
// ----------------------------------------------------------------------------
// tb_descending_stable_top_k_sorter
// Self-checking bench for the descending stable top-k sorter. Records go in
// as sets closed by a last beat, and a local ranking model (stable insert,
// capped store, clamped output limit) predicts each ranked result. The
// output_limit register is swept over APB between sets, and both handshakes
// see random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_descending_stable_top_k_sorter;
  import dstk_pkg::*;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned RandomRecords = 115;
  localparam logic [2:0] LimitAddr = {RegOutputLimit, 2'b00};

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // ranking model state
  rec_t              held_records[$];
  logic [LimitW-1:0] cur_limit;
  out_t              pending_ranks[$];

  int fail_count = 0;
  int sets_closed = 0;
  int records_sent = 0;
  int records_dropped = 0;
  int results_checked = 0;
  int limit_writes = 0;
  int burst_left = 0;
  int ready_run = 0;
  int cycle_count = 0;

  descending_stable_top_k_sorter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Insert one accepted record, and on the last beat emit the ranked set.
  task automatic update_ranking(input in_t rec);
    int   pos;
    int   lim;
    int   n;
    rec_t r;
    out_t o;
    if (held_records.size() < StoreDepth) begin
      pos = 0;
      // equal keys go behind earlier ones
      while (pos < held_records.size() && held_records[pos].key >= rec.sort_key) pos++;
      r.key = rec.sort_key;
      r.tag = rec.record_tag;
      held_records.insert(pos, r);
    end else begin
      records_dropped++;
    end
    if (rec.last_record) begin
      lim = (cur_limit == 0) ? 1 : int'(cur_limit);
      if (lim > int'(MaxResults)) lim = int'(MaxResults);
      n = (held_records.size() < lim) ? held_records.size() : lim;
      for (int k = 0; k < n; k++) begin
        o.rank         = RankW'(k + 1);
        o.ranked_key   = held_records[k].key;
        o.ranked_tag   = held_records[k].tag;
        o.final_result = (k == n - 1);
        pending_ranks.push_back(o);
      end
      held_records.delete();
      sets_closed++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_ranks.size() == 0) begin
        $error("unexpected result beat: rank %0d key %h tag %0d",
               out_data_o.rank, out_data_o.ranked_key, out_data_o.ranked_tag);
        fail_count++;
      end else begin
        want = pending_ranks.pop_front();
        results_checked++;
        if (out_data_o.rank !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, out_data_o.rank);
          fail_count++;
        end
        if (out_data_o.ranked_key !== want.ranked_key) begin
          $error("ranked_key: expected %h, got %h", want.ranked_key, out_data_o.ranked_key);
          fail_count++;
        end
        if (out_data_o.ranked_tag !== want.ranked_tag) begin
          $error("ranked_tag: expected %0d, got %0d", want.ranked_tag, out_data_o.ranked_tag);
          fail_count++;
        end
        if (out_data_o.final_result !== want.final_result) begin
          $error("final_result: expected %0d, got %0d",
                 want.final_result, out_data_o.final_result);
          fail_count++;
        end
      end
    end
  end

  // receiver: runs of ready and stall of random length, some long
  always @(negedge clk_i) begin : drive_out_ready
    int pick;
    if (ready_run == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        out_ready_i = 1'b1;
        ready_run = $urandom_range(1, 4);
      end else if (pick < 7) begin
        out_ready_i = 1'b0;
        ready_run = $urandom_range(1, 3);
      end else if (pick == 7) begin
        out_ready_i = 1'b0;
        ready_run = $urandom_range(8, 15);
      end else begin
        out_ready_i = 1'b1;
        ready_run = $urandom_range(20, 40);
      end
    end
    ready_run--;
  end

  function automatic in_t make_record(input logic [15:0] key, input logic [5:0] tag,
                                      input logic last);
    in_t rec;
    rec.sort_key    = key;
    rec.record_tag  = tag;
    rec.last_record = last;
    return rec;
  endfunction

  function automatic in_t random_record(input logic last);
    in_t rec;
    case ($urandom_range(0, 3))
      0: rec.sort_key = 16'($urandom_range(0, 3));  // dense keys, many ties
      1: rec.sort_key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: rec.sort_key = 16'($urandom);
    endcase
    rec.record_tag  = 6'($urandom);
    rec.last_record = last;
    return rec;
  endfunction

  // One input beat; the sender idles in gaps between bursts.
  task automatic send_record(input in_t rec);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = rec;
    do @(posedge clk_i); while (!in_ready_o);
    update_ranking(rec);
    records_sent++;
    burst_left--;
  endtask

  task automatic send_random_set(input int count);
    for (int i = 0; i < count; i++) send_record(random_record(i == count - 1));
  endtask

  task automatic wait_results_done();
    int guard;
    guard = 0;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_ranks.size() != 0 && guard < 50000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_ranks.size() != 0) begin
      $error("%0d ranked results never arrived", pending_ranks.size());
      fail_count++;
      pending_ranks.delete();
    end
    repeat (10) @(posedge clk_i);
  endtask

  // APB write of output_limit, then read it back
  task automatic write_output_limit(input logic [LimitW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = LimitAddr;
    pwdata  = {25'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    cur_limit = value;
    limit_writes++;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== {25'd0, value}) begin
      $error("output_limit readback: expected %0d, got %0d", value, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_extremes();
    logic [15:0] keys[8] = '{16'hAAAA, 16'h5555, 16'h0001, 16'h8000,
                             16'h7FFF, 16'hFFFE, 16'h0100, 16'h00FF};
    logic [5:0]  tags[8] = '{6'd21, 6'd42, 6'd1, 6'd32, 6'd31, 6'd62, 6'd4, 6'd3};
    send_record(make_record(16'hFFFF, 6'd63, 1'b1));
    send_record(make_record(16'h0000, 6'd0, 1'b1));
    for (int i = 0; i < 8; i++) send_record(make_record(keys[i], tags[i], i == 7));
    wait_results_done();
  endtask

  task automatic test_stable_ties();
    logic [15:0] keys[8] = '{16'd5, 16'd5, 16'd9, 16'd5, 16'd9, 16'd0, 16'hFFFF, 16'd0};
    for (int i = 0; i < 8; i++) send_record(make_record(keys[i], 6'(i + 1), i == 7));
    wait_results_done();
  endtask

  task automatic test_output_limits();
    write_output_limit(7'd1);
    send_random_set(6);
    wait_results_done();
    // zero behaves as one
    write_output_limit(7'd0);
    send_random_set(5);
    wait_results_done();
    // above the result cap; the set size bounds it
    write_output_limit(7'd127);
    send_random_set(20);
    wait_results_done();
  endtask

  task automatic test_store_full();
    write_output_limit(MaxResults);
    // last beat lands on a dropped record and still closes the set
    send_random_set(70);
    wait_results_done();
  endtask

  task automatic test_random_sets();
    int start;
    int count;
    start = records_sent;
    while (records_sent - start < RandomRecords) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_results_done();
        case ($urandom_range(0, 5))
          0: write_output_limit(7'd0);
          1: write_output_limit(7'd127);
          2: write_output_limit(7'd1);
          default: write_output_limit(LimitW'($urandom_range(1, 64)));
        endcase
      end
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 10);
      send_random_set(count);
    end
    wait_results_done();
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    cur_limit  = LimitDefault;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_stable_ties();
    test_output_limits();
    test_store_full();
    test_random_sets();

    $display("Covered %0d sets from %0d records (%0d dropped on a full store)",
             sets_closed, records_sent, records_dropped);
    $display("Checked %0d ranked results across %0d output_limit writes",
             results_checked, limit_writes);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
